// ===== rtl/set_assoc_cache_lru_lookup_assert.svh =====
// Assertion macros shared by the cache lookup RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache lookup check failed");

// The consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache lookup check failed");

`endif

// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

  localparam int SET_INDEX_BITS_DEFAULT = 10;
  localparam int WAYS_DEFAULT = 8;

  localparam int TAG_W = 32;
  localparam int CFG_W = 4;
  localparam int RANK_W = 3;
  localparam int WAY_CNT_W = 7;

  // Configuration register indexes.
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_SET_BITS = 2'd1;
  localparam logic [1:0] REG_ACTIVE_WAYS = 2'd2;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RESET = 4'd6;
  localparam logic [CFG_W-1:0] SET_BITS_RESET = 4'd6;
  localparam logic [CFG_W-1:0] ACTIVE_WAYS_RESET = 4'd1;

  // One stored entry of a way: valid flag and tag.
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Search state that ripples from rank 0 toward the last way.
  typedef struct packed {
    logic              alive;
    logic              found;
    logic [RANK_W-1:0] rank;
  } chain_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic read;
    logic update;
    logic clear;
    logic hit;
  } ctrl_t;

endpackage

// ===== rtl/sacl_ram.sv =====
module sacl_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/sacl_cell.sv =====
// One recency rank of every set: its tag memory plus the search and shift logic.
module sacl_cell #(
  parameter int IDX = 0,
  parameter int SET_INDEX_BITS = sacl_pkg::SET_INDEX_BITS_DEFAULT,
  localparam int SET_AW = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1
) (
  input  logic                          clk,
  input  sacl_pkg::ctrl_t               ctrl,
  input  logic [SET_AW-1:0]             rd_addr,
  input  logic [SET_AW-1:0]             wr_addr,
  input  logic [sacl_pkg::TAG_W-1:0]    tag,
  input  logic [sacl_pkg::CFG_W-1:0]    ways,
  input  sacl_pkg::entry_t              nbr_in,
  output sacl_pkg::entry_t              entry_out,
  input  sacl_pkg::chain_t              chain_in,
  output sacl_pkg::chain_t              chain_out,
  output logic                          last
);

  localparam logic [sacl_pkg::WAY_CNT_W-1:0] POS = sacl_pkg::WAY_CNT_W'(IDX);

  logic [sacl_pkg::WAY_CNT_W-1:0] ways_ext;
  logic in_use;
  logic match;
  logic shift;
  logic wr_en;
  sacl_pkg::entry_t wr_data;

  assign ways_ext = sacl_pkg::WAY_CNT_W'(ways);
  assign in_use = POS < ways_ext;

  assign chain_out.alive = chain_in.alive & entry_out.valid & in_use;
  assign match = chain_out.alive & (entry_out.tag == tag);
  assign chain_out.found = chain_in.found | match;
  assign chain_out.rank = chain_in.rank |
                          ((match & ~chain_in.found) ? POS[sacl_pkg::RANK_W-1:0]
                                                     : '0);
  assign last = chain_out.alive & (POS == ways_ext - 1'b1);

  // On a hit every rank up to the hit moves; on a miss every rank up to the
  // first free slot moves, capped at the last active way.
  assign shift = ctrl.hit ? ~chain_in.found : (chain_in.alive & in_use);
  assign wr_en = ctrl.clear | (ctrl.update & shift);
  assign wr_data = ctrl.clear ? '0 : nbr_in;

  sacl_ram #(
    .WIDTH($bits(sacl_pkg::entry_t)),
    .DEPTH(2 ** SET_INDEX_BITS)
  ) u_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(ctrl.read),
    .rd_addr(rd_addr),
    .rd_data(entry_out)
  );

endmodule

// ===== rtl/set_assoc_cache_lru_lookup.sv =====
// result_valid is registered: an accepted address is read from the way memories, and
// result_valid rises at the end of the write-back; no new address is taken until then.
// A stalled result holds the block in its write-back cycle until the result is taken.
// Reset restores the configuration registers and then sweeps every set to clear the
// valid flags, one set per cycle, with address_stall high.
module set_assoc_cache_lru_lookup #(
  parameter int SET_INDEX_BITS = sacl_pkg::SET_INDEX_BITS_DEFAULT,
  parameter int WAYS = sacl_pkg::WAYS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [sacl_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           address_valid,
  output logic                           address_stall,
  input  logic [31:0]                    address,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic                           hit,
  output logic [sacl_pkg::RANK_W-1:0]    hit_rank,
  output logic                           evicted
);

`include "set_assoc_cache_lru_lookup_assert.svh"

  localparam int SET_AW = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
  localparam logic [SET_AW-1:0] LAST_SET = SET_AW'(2 ** SET_INDEX_BITS - 1);
  localparam logic [4:0] SET_LIMIT = 5'(SET_INDEX_BITS);
  localparam logic [sacl_pkg::WAY_CNT_W-1:0] WAY_LIMIT = sacl_pkg::WAY_CNT_W'(WAYS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP
  } state_t;

  state_t state;

  // Configuration registers.
  logic [sacl_pkg::CFG_W-1:0] offset_bits;
  logic [sacl_pkg::CFG_W-1:0] set_bits;
  logic [sacl_pkg::CFG_W-1:0] active_ways;

  // The access in flight: its set, tag and the clamped way count.
  logic [SET_AW-1:0]          cur_set;
  logic [sacl_pkg::TAG_W-1:0] cur_tag;
  logic [sacl_pkg::CFG_W-1:0] cur_ways;
  logic [SET_AW-1:0]          clr_addr;

  // Address split for the incoming item.
  logic [4:0]                 sb;
  logic [4:0]                 tag_shift;
  logic [31:0]                set_full;
  logic [SET_AW-1:0]          in_set;
  logic [sacl_pkg::TAG_W-1:0] in_tag;
  logic [sacl_pkg::CFG_W-1:0] in_ways;

  logic accept;
  logic finish;
  logic evict_any;

  sacl_pkg::ctrl_t  ctrl;
  sacl_pkg::chain_t chain [WAYS+1];
  sacl_pkg::entry_t entries [WAYS+1];
  logic [WAYS-1:0]  last_vec;
  logic [SET_AW-1:0] wr_addr;

  // Set widths beyond the index width of the memory saturate. The offset is
  // used as written, so the combined shift stays at most 31.
  assign sb = ({1'b0, set_bits} > SET_LIMIT) ? SET_LIMIT : {1'b0, set_bits};
  assign tag_shift = {1'b0, offset_bits} + sb;
  assign set_full = (address >> offset_bits) & ~(32'hFFFF_FFFF << sb);
  assign in_set = set_full[SET_AW-1:0];
  assign in_tag = address >> tag_shift;

  // A way count of zero acts as direct mapped; counts beyond the built ways clamp.
  always_comb begin
    if (active_ways == '0) begin
      in_ways = sacl_pkg::CFG_W'(1);
    end else if (sacl_pkg::WAY_CNT_W'(active_ways) > WAY_LIMIT) begin
      in_ways = sacl_pkg::CFG_W'(WAYS);
    end else begin
      in_ways = active_ways;
    end
  end

  assign address_stall = (state != S_IDLE);
  assign accept = address_valid & ~address_stall;

  // The write-back cycle waits only while an earlier result is still stalled.
  assign finish = (state == S_LOOKUP) & (~result_valid | ~result_stall);

  assign ctrl.read = accept;
  assign ctrl.update = finish;
  assign ctrl.clear = (state == S_CLEAR);
  assign ctrl.hit = chain[WAYS].found;
  assign wr_addr = (state == S_CLEAR) ? clr_addr : cur_set;

  // The head of the row sees an empty search and offers the new tag as the
  // entry that moves into rank 0.
  assign chain[0] = '{alive: 1'b1, found: 1'b0, rank: '0};
  assign entries[0] = '{valid: 1'b1, tag: cur_tag};

  // Each cell holds one recency rank for all sets. During write-back a cell
  // that shifts takes the entry of the rank in front of it, so all the shifting
  // ranks of the set move down by one place together.
  for (genvar j = 0; j < WAYS; j++) begin : g_cell
    sacl_cell #(
      .IDX(j),
      .SET_INDEX_BITS(SET_INDEX_BITS)
    ) u_cell (
      .clk(clk),
      .ctrl(ctrl),
      .rd_addr(in_set),
      .wr_addr(wr_addr),
      .tag(cur_tag),
      .ways(cur_ways),
      .nbr_in(entries[j]),
      .entry_out(entries[j+1]),
      .chain_in(chain[j]),
      .chain_out(chain[j+1]),
      .last(last_vec[j])
    );
  end

  // A miss evicts when every active way held a valid entry.
  assign evict_any = |last_vec;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= sacl_pkg::OFFSET_BITS_RESET;
      set_bits <= sacl_pkg::SET_BITS_RESET;
      active_ways <= sacl_pkg::ACTIVE_WAYS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sacl_pkg::REG_OFFSET_BITS: offset_bits <= cfg_data;
        sacl_pkg::REG_SET_BITS:    set_bits <= cfg_data;
        sacl_pkg::REG_ACTIVE_WAYS: active_ways <= cfg_data;
        default: ;
      endcase
    end
  end

  // The result payload registers need no reset; result_valid guards them.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      result_valid <= 1'b0;
    end else begin
      // A finishing lookup may replace a result that is taken in the same cycle.
      if (finish) begin
        result_valid <= 1'b1;
        hit <= chain[WAYS].found;
        hit_rank <= chain[WAYS].rank;
        evicted <= ~chain[WAYS].found & evict_any;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_SET) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Item registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_set <= in_set;
      cur_tag <= in_tag;
      cur_ways <= in_ways;
    end
  end

  `SACL_ASSERT_NEXT(a_accept_starts_lookup, accept, state == S_LOOKUP)
  `SACL_ASSERT_SAME(a_hit_never_evicts, result_valid, !(hit && evicted))
  `SACL_ASSERT_SAME(a_miss_rank_zero, result_valid && !hit, hit_rank == '0)
  `SACL_ASSERT_SAME(a_single_last_way, state == S_LOOKUP, $onehot0(last_vec))

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sacl_pkg::*;

  // The block is built with its default geometry, so the shadow copy of the
  // lookup state uses the same sizes.
  localparam int SETS_W = SET_INDEX_BITS_DEFAULT;
  localparam int NSETS = 1 << SETS_W;
  localparam int NWAYS = WAYS_DEFAULT;

  // Index 3 is not a register of the block; a write to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // Cycles that the block may still need after its last result before it is
  // safe to touch the registers, and the settle time at the end of the run.
  localparam int WRITEBACK_SETTLE = 4;
  localparam int END_SETTLE = 10;

  typedef struct {
    bit              hit;
    bit [RANK_W-1:0] rank;
    bit              evicted;
  } lookup_result_t;

  typedef enum {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_LONG
  } stall_mode_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             address_valid = 1'b0;
  logic             address_stall;
  logic [31:0]      address = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic             hit;
  logic [RANK_W-1:0] hit_rank;
  logic             evicted;

  set_assoc_cache_lru_lookup dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .address_valid(address_valid),
    .address_stall(address_stall),
    .address      (address),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .hit          (hit),
    .hit_rank     (hit_rank),
    .evicted      (evicted)
  );

  always #6 clk = ~clk;

  // Shadow copy of the register file as the block should hold it.
  logic [CFG_W-1:0] shadow_offset_bits = OFFSET_BITS_RESET;
  logic [CFG_W-1:0] shadow_set_bits = SET_BITS_RESET;
  logic [CFG_W-1:0] shadow_active_ways = ACTIVE_WAYS_RESET;

  // Shadow copy of the tag and valid arrays. Each set is kept in recency
  // order: way 0 is the most recently used line.
  logic [TAG_W-1:0] line_tag [NSETS][NWAYS];
  bit               line_valid [NSETS][NWAYS];

  logic [31:0]    address_backlog [$];
  lookup_result_t lookup_expected [$];

  int error_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int hit_count = 0;
  int evict_count = 0;
  int setting_count = 0;

  // Effective geometry under the current registers. An oversized set width
  // saturates at the built index width, and a way count of zero or of more
  // than the built associativity is clamped into range.
  function automatic int unsigned eff_set_bits();
    return (shadow_set_bits > SETS_W) ? SETS_W : shadow_set_bits;
  endfunction

  function automatic int unsigned eff_ways();
    if (shadow_active_ways == 0)
      return 1;
    return (shadow_active_ways > NWAYS) ? NWAYS : shadow_active_ways;
  endfunction

  // Looks one address up in the shadow arrays, applies the LRU update and
  // returns what the block must report for it.
  function automatic lookup_result_t predict_lookup(input logic [31:0] addr);
    int unsigned    sb;
    int unsigned    ob;
    int unsigned    nways;
    int unsigned    set_idx;
    int unsigned    count;
    int unsigned    top;
    logic [31:0]    tag;
    lookup_result_t res;
    sb = eff_set_bits();
    ob = shadow_offset_bits;
    nways = eff_ways();
    set_idx = (addr >> ob) & ((32'd1 << sb) - 1);
    tag = addr >> (ob + sb);
    res.hit = 1'b0;
    res.rank = '0;
    res.evicted = 1'b0;
    // Only the leading run of valid lines inside the active ways is live.
    // Lines past the active ways survive a narrowing of the associativity
    // and come back into play when it is widened again.
    count = 0;
    while (count < nways && line_valid[set_idx][count])
      count++;
    top = count;
    for (int i = 0; i < count; i++) begin
      if (!res.hit && line_tag[set_idx][i] == tag) begin
        res.hit = 1'b1;
        res.rank = i[RANK_W-1:0];
        top = i;
      end
    end
    if (!res.hit && count == nways) begin
      res.evicted = 1'b1;
      top = nways - 1;
    end
    for (int j = top; j >= 1; j--) begin
      line_tag[set_idx][j] = line_tag[set_idx][j-1];
      line_valid[set_idx][j] = line_valid[set_idx][j-1];
    end
    line_tag[set_idx][0] = tag;
    line_valid[set_idx][0] = 1'b1;
    return res;
  endfunction

  // Address driver. It sends the backlog in bursts of random length with
  // random gaps, and now and then holds off until every expected result
  // has come back, so the block also sees a completely drained pipeline.
  int  burst_left = 0;
  int  gap_left = 0;
  bit  draining = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      address_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      draining = 1'b0;
    end else begin
      if (address_valid && !address_stall) begin
        lookup_expected.push_back(predict_lookup(address));
        accepted_count++;
      end
      if (address_valid && address_stall) begin
        // The item waits; valid and address stay as they are.
      end else if (draining && lookup_expected.size() != 0) begin
        address_valid <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        address_valid <= 1'b0;
      end else if (address_backlog.size() != 0) begin
        draining = 1'b0;
        address <= address_backlog.pop_front();
        address_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          draining = ($urandom_range(0, 15) == 0);
        end else begin
          burst_left--;
        end
      end else begin
        address_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern. It switches between no stalls, random stalls, a
  // regular periodic stall and long stretches of stall, so that back-pressure
  // lands on both the read and the write-back of the block.
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          stall_run = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_mode = STALL_NONE;
      mode_left = 0;
      stall_run = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE: begin
          result_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          result_stall <= ($urandom_range(0, 2) == 0);
        end
        STALL_PERIODIC: begin
          result_stall <= (mode_left % 4 == 0);
        end
        default: begin
          if (stall_run > 0) begin
            stall_run--;
            result_stall <= 1'b1;
          end else begin
            result_stall <= 1'b0;
            stall_run = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : 0;
          end
        end
      endcase
    end
  end

  // Result monitor: every accepted result is checked field by field against
  // the oldest outstanding expectation.
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (lookup_expected.size() == 0) begin
        $display("%0t: result with nothing outstanding: hit %0b rank %0d evicted %0b",
                 $time, hit, hit_rank, evicted);
        error_count++;
      end else begin
        want = lookup_expected.pop_front();
        checked_count++;
        if (hit !== want.hit) begin
          $display("%0t: hit expected %0b, got %0b", $time, want.hit, hit);
          error_count++;
        end
        if (hit_rank !== want.rank) begin
          $display("%0t: hit_rank expected %0d, got %0d", $time, want.rank, hit_rank);
          error_count++;
        end
        if (evicted !== want.evicted) begin
          $display("%0t: evicted expected %0b, got %0b", $time, want.evicted, evicted);
          error_count++;
        end
        if (want.hit)
          hit_count++;
        if (want.evicted)
          evict_count++;
      end
    end
  end

  // Waits until the driver has nothing left and every result is back, then
  // lets the block finish its last write-back.
  task automatic wait_idle();
    @(negedge clk);
    while (address_backlog.size() != 0 || address_valid || lookup_expected.size() != 0)
      @(negedge clk);
    repeat (WRITEBACK_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_OFFSET_BITS: shadow_offset_bits = val;
      REG_SET_BITS: shadow_set_bits = val;
      REG_ACTIVE_WAYS: shadow_active_ways = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Moves the block to a new register setting once it is idle.
  task automatic configure(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] sets,
                           input logic [CFG_W-1:0] ways, input bit poke_unused);
    wait_idle();
    write_reg(REG_OFFSET_BITS, off);
    write_reg(REG_SET_BITS, sets);
    write_reg(REG_ACTIVE_WAYS, ways);
    if (poke_unused)
      write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 15)));
    setting_count++;
    @(negedge clk);
  endtask

  // Random accesses under the current setting. Most of them cycle through
  // a small pool of sets and a pool of tags equal to or a little larger than the active
  // associativity, so sets fill up, hit at every rank and evict. The rest
  // are fully random addresses.
  task automatic random_accesses(input int n);
    int unsigned sb;
    int unsigned ob;
    int          nsets;
    int          ntags;
    logic [31:0] set_pool [$];
    logic [31:0] tag_pool [$];
    logic [63:0] composed;
    sb = eff_set_bits();
    ob = shadow_offset_bits;
    nsets = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 64) : $urandom_range(1, 3);
    ntags = eff_ways() + $urandom_range(0, 3);
    for (int i = 0; i < nsets; i++)
      set_pool.push_back($urandom & ((32'd1 << sb) - 1));
    for (int i = 0; i < ntags; i++)
      tag_pool.push_back($urandom);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        address_backlog.push_back($urandom);
      end else begin
        composed = ({32'd0, tag_pool[$urandom_range(0, ntags - 1)]} << (ob + sb))
                 | ({32'd0, set_pool[$urandom_range(0, nsets - 1)]} << ob)
                 | {32'd0, $urandom & ((32'd1 << ob) - 1)};
        address_backlog.push_back(composed[31:0]);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] off;
    logic [CFG_W-1:0] sets;
    logic [CFG_W-1:0] ways;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setting, direct mapped: a repeated address hits, a different
    // tag in the same set evicts, and offset bits do not affect the lookup.
    setting_count++;
    address_backlog.push_back(32'h0000_0000);
    address_backlog.push_back(32'h0000_0000);
    address_backlog.push_back(32'h0000_1000);
    address_backlog.push_back(32'hFFFF_FFFF);
    address_backlog.push_back(32'hFFFF_FFC0);
    address_backlog.push_back(32'h0000_0000);

    // One set, eight ways: fill the set without eviction, hit at the
    // deepest rank, then evict and hit again. The unused register index is
    // written along the way and must have no effect.
    configure(4'd0, 4'd0, 4'd8, 1'b1);
    for (int i = 0; i < 8; i++)
      address_backlog.push_back(32'(i));
    address_backlog.push_back(32'd0);
    address_backlog.push_back(32'd8);
    address_backlog.push_back(32'd8);

    // Widest offset, set width above the built index width, and a way
    // count of zero that acts as direct mapped.
    configure(4'd15, 4'd15, 4'd0, 1'b0);
    address_backlog.push_back(32'hFFFF_FFFF);
    address_backlog.push_back(32'hFFFF_FFFF);
    address_backlog.push_back(32'h0000_0000);
    address_backlog.push_back(32'h7FFF_FFFF);

    // Associativity narrowed on a full set: misses evict from the first two
    // ways while the deeper lines stay in place.
    configure(4'd0, 4'd0, 4'd2, 1'b0);
    address_backlog.push_back(32'd50);
    address_backlog.push_back(32'd3);

    // Associativity widened past the built count: the kept deep lines are
    // searched again.
    configure(4'd0, 4'd0, 4'd12, 1'b0);
    address_backlog.push_back(32'd2);
    address_backlog.push_back(32'd3);

    // Random settings, the first few at the extremes of the register ranges.
    for (int p = 0; p < 16; p++) begin
      case (p)
        0: begin off = 4'd12; sets = 4'd10; ways = 4'd8; end
        1: begin off = 4'd0; sets = 4'd0; ways = 4'd15; end
        2: begin off = 4'd15; sets = 4'd11; ways = 4'd1; end
        3: begin off = 4'd3; sets = 4'd1; ways = 4'd4; end
        default: begin
          off = CFG_W'($urandom_range(0, 15));
          sets = CFG_W'($urandom_range(0, 15));
          ways = CFG_W'($urandom_range(0, 15));
        end
      endcase
      configure(off, sets, ways, $urandom_range(0, 3) == 0);
      random_accesses(84);
    end

    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    $display("Ran %0d accesses under %0d register settings; %0d results checked.",
             accepted_count, setting_count, checked_count);
    $display("Of those, %0d were hits and %0d misses evicted a line.",
             hit_count, evict_count);
    if (error_count == 0 && lookup_expected.size() == 0) begin
      $display("** set_assoc_cache_lru_lookup: PASSED **");
    end else begin
      $display("** set_assoc_cache_lru_lookup: FAILED **");
    end
    $finish;
  end

  // Watchdog. A correct run, including the clearing sweep after reset and
  // the worst stalls and gaps, finishes well inside this time.
  initial begin
    #(5_000_000);
    $display("Timed out with %0d results outstanding.", lookup_expected.size());
    $display("** set_assoc_cache_lru_lookup: FAILED **");
    $finish;
  end

endmodule

// ===== set_assoc_cache_lru_lookup.f =====
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_cell.sv
rtl/set_assoc_cache_lru_lookup.sv
tb/tb.sv
